@@ rtl/core/hav_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hav_pkg
// Shared types, fixed-point constants and the arctangent table for the
// great-circle distance pipeline.
// ----------------------------------------------------------------------------
package hav_pkg;

    typedef logic signed [33:0] t_q30;

    localparam t_q30 DEG360_Q23 = 34'sd3019898880;
    localparam t_q30 DEG180_Q23 = 34'sd1509949440;
    localparam t_q30 DEG90_Q23  = 34'sd754974720;
    localparam logic signed [25:0] DEG_TO_RAD_Q30 = 26'sd18740330;
    localparam t_q30 INV_GAIN_Q30 = 34'sd652032874;
    localparam t_q30 ONE_Q30 = 34'sd1073741824;
    localparam logic [23:0] RADIUS_RESET = 24'd6371000;

    // Truncated atan(2^-i) in Q30 radians.
    function automatic logic [31:0] atan_q30(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd843314856;
            1:  v = 32'd497837829;
            2:  v = 32'd263043836;
            3:  v = 32'd133525158;
            4:  v = 32'd67021686;
            5:  v = 32'd33543515;
            6:  v = 32'd16775850;
            7:  v = 32'd8388437;
            8:  v = 32'd4194282;
            9:  v = 32'd2097149;
            10: v = 32'd1048575;
            11: v = 32'd524287;
            12: v = 32'd262143;
            13: v = 32'd131071;
            14: v = 32'd65535;
            15: v = 32'd32767;
            16: v = 32'd16383;
            17: v = 32'd8191;
            18: v = 32'd4095;
            19: v = 32'd2047;
            20: v = 32'd1023;
            21: v = 32'd511;
            22: v = 32'd255;
            23: v = 32'd127;
            24: v = 32'd63;
            25: v = 32'd31;
            26: v = 32'd15;
            27: v = 32'd7;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/hav_angle.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hav_angle
// Reduces a Q23 degree angle into -90..90 degrees, noting a fold, and converts
// it to Q30 radians. Two register stages.
// ----------------------------------------------------------------------------
module hav_angle
    import hav_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire logic signed [31:0] i_deg,
    output logic                    o_vld,
    output t_q30                    o_rad,
    output logic                    o_flip
);

    t_q30                     n_fold;
    logic                     n_flip;
    t_q30                     w_wrap;
    t_q30                     w_deg;
    logic signed [31:0]       r_fold;
    logic                     r_flip1;
    logic                     r_vld1;
    logic signed [57:0]       r_prod;
    logic                     r_flip2;
    logic                     r_vld2;

    always_comb begin
        w_deg = t_q30'(i_deg);
        if (w_deg >= DEG180_Q23) begin
            w_wrap = w_deg - DEG360_Q23;
        end else if (w_deg < -DEG180_Q23) begin
            w_wrap = w_deg + DEG360_Q23;
        end else begin
            w_wrap = w_deg;
        end
        n_flip = 1'b0;
        n_fold = w_wrap;
        if (w_wrap > DEG90_Q23) begin
            n_fold = DEG180_Q23 - w_wrap;
            n_flip = 1'b1;
        end else if (w_wrap < -DEG90_Q23) begin
            n_fold = -DEG180_Q23 - w_wrap;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fold  <= n_fold[31:0];
            r_flip1 <= n_flip;
            r_prod  <= r_fold * DEG_TO_RAD_Q30;
            r_flip2 <= r_flip1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    assign o_rad  = t_q30'(r_prod >>> 23);
    assign o_flip = r_flip2;
    assign o_vld  = r_vld2;

endmodule
`default_nettype wire

@@ rtl/core/hav_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hav_cordic
// Unrolled CORDIC, one register stage per iteration. Rotation mode gives
// sine and cosine; vectoring mode gives the angle of (x, y).
// ----------------------------------------------------------------------------
module hav_cordic
    import hav_pkg::*;
#(
    parameter int STAGES = 24,
    parameter bit VECTOR = 1'b0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_vld,
    input  wire t_q30 i_x,
    input  wire t_q30 i_y,
    input  wire t_q30 i_z,
    input  wire logic i_flip,
    output logic      o_vld,
    output t_q30      o_x,
    output t_q30      o_y,
    output t_q30      o_z
);

    t_q30 r_x [STAGES];
    t_q30 r_y [STAGES];
    t_q30 r_z [STAGES];
    logic r_f [STAGES];
    logic r_v [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        t_q30 x_in, y_in, z_in, dx, dy, tv;
        logic f_in, v_in, rot;
        if (g == 0) begin : g_first
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = i_z;
            assign f_in = i_flip;
            assign v_in = i_vld;
        end else begin : g_next
            assign x_in = r_x[g-1];
            assign y_in = r_y[g-1];
            assign z_in = r_z[g-1];
            assign f_in = r_f[g-1];
            assign v_in = r_v[g-1];
        end
        assign dx  = y_in >>> g;
        assign dy  = x_in >>> g;
        assign tv  = {2'b00, atan_q30(g)};
        assign rot = VECTOR ? !(y_in > 0) : (z_in >= 0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g] <= rot ? x_in - dx : x_in + dx;
                r_y[g] <= rot ? y_in + dy : y_in - dy;
                r_z[g] <= rot ? z_in - tv : z_in + tv;
                r_f[g] <= f_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
        end
    end

    // A fold past 90 degrees negates the cosine.
    assign o_x   = r_f[STAGES-1] ? -r_x[STAGES-1] : r_x[STAGES-1];
    assign o_y   = r_y[STAGES-1];
    assign o_z   = r_z[STAGES-1];
    assign o_vld = r_v[STAGES-1];

endmodule
`default_nettype wire

@@ rtl/core/hav_mix.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hav_mix
// Forms a = sin^2(dlat/2) + cos1*cos2*sin^2(dlon/2), clamps it to 0..1 and
// gives 1-a alongside. Three register stages.
// ----------------------------------------------------------------------------
module hav_mix
    import hav_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_q30  i_s_lat,
    input  wire t_q30  i_s_lon,
    input  wire t_q30  i_c1,
    input  wire t_q30  i_c2,
    output logic       o_vld,
    output logic [30:0] o_a,
    output logic [30:0] o_b
);

    logic signed [31:0] w_sl, w_sn, w_c1, w_c2;
    logic signed [63:0] w_pl, w_pn, w_pc;
    logic signed [67:0] w_pp;
    logic signed [34:0] w_sum;
    t_q30               r_sql, r_sqn, r_c12, r_sql2, r_p;
    logic [30:0]        n_a, r_a, r_b;
    logic [2:0]         r_v;

    assign w_sl = i_s_lat[31:0];
    assign w_sn = i_s_lon[31:0];
    assign w_c1 = i_c1[31:0];
    assign w_c2 = i_c2[31:0];
    assign w_pl = w_sl * w_sl;
    assign w_pn = w_sn * w_sn;
    assign w_pc = w_c1 * w_c2;
    assign w_pp = r_c12 * r_sqn;
    assign w_sum = 35'(r_sql2) + 35'(r_p);

    always_comb begin
        if (w_sum < 0) begin
            n_a = '0;
        end else if (w_sum > 35'(ONE_Q30)) begin
            n_a = ONE_Q30[30:0];
        end else begin
            n_a = w_sum[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sql  <= t_q30'(w_pl >>> 30);
            r_sqn  <= t_q30'(w_pn >>> 30);
            r_c12  <= t_q30'(w_pc >>> 30);
            r_sql2 <= r_sql;
            r_p    <= t_q30'(w_pp >>> 30);
            r_a    <= n_a;
            r_b    <= ONE_Q30[30:0] - n_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_vld};
        end
    end

    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_vld = r_v[2];

endmodule
`default_nettype wire

@@ rtl/core/hav_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hav_isqrt
// Integer square root, one result bit per register stage, 32 stages.
// ----------------------------------------------------------------------------
module hav_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  wire logic [63:0] i_n,
    output logic             o_vld,
    output logic [31:0]      o_root
);

    localparam int STEPS = 32;

    logic [63:0] r_n   [STEPS];
    logic [63:0] r_res [STEPS];
    logic        r_v   [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [63:0] n_in, res_in, sum;
        logic        v_in;
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        if (k == 0) begin : g_first
            assign n_in   = i_n;
            assign res_in = '0;
            assign v_in   = i_vld;
        end else begin : g_next
            assign n_in   = r_n[k-1];
            assign res_in = r_res[k-1];
            assign v_in   = r_v[k-1];
        end
        assign sum = res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_in >= sum) begin
                    r_n[k]   <= n_in - sum;
                    r_res[k] <= (res_in >> 1) + BIT;
                end else begin
                    r_n[k]   <= n_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end
    end

    assign o_root = r_res[STEPS-1][31:0];
    assign o_vld  = r_v[STEPS-1];

endmodule
`default_nettype wire

@@ rtl/core/haversine_distance.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// Reset: synchronous active-low; clears all valid bits and sets the radius
// to 6371000.
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance between two points, fully pipelined: angle reduction,
// four sine/cosine CORDICs, the haversine term, two square roots, an atan2
// CORDIC and the radius scaling.
// ----------------------------------------------------------------------------
module haversine_distance
    import hav_pkg::*;
#(
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [23:0]        i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [29:0] i_first_latitude,
    input  wire logic signed [30:0] i_first_longitude,
    input  wire logic signed [29:0] i_second_latitude,
    input  wire logic signed [30:0] i_second_longitude,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [41:0]             o_arc_distance
);

    logic               en;
    logic [23:0]        r_radius;
    logic signed [31:0] r_dlat, r_dlon, r_lat1, r_lat2;
    logic               r_p1_vld;

    logic [3:0]         ang_vld, ang_flip;
    t_q30               ang_rad [4];
    logic [3:0]         cs_vld;
    t_q30               cs_x [4];
    t_q30               cs_y [4];
    t_q30               cs_z [4];

    logic               mix_vld;
    logic [30:0]        mix_a, mix_b;
    logic               sq_vld_a, sq_vld_b;
    logic [31:0]        root_a, root_b;
    logic               at_vld;
    t_q30               at_x, at_y, at_z;

    logic [31:0]        w_ang2;
    logic [55:0]        r_prod;
    logic               r_f1_vld;
    logic [41:0]        r_dist;
    logic               r_out_vld;

    // Every stage moves while the output register is empty or being read.
    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // Half differences are the raw differences read as Q23; latitudes are
    // doubled into the same format.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dlat <= 32'(i_second_latitude) - 32'(i_first_latitude);
            r_dlon <= 32'(i_second_longitude) - 32'(i_first_longitude);
            r_lat1 <= {{1{i_first_latitude[29]}}, i_first_latitude, 1'b0};
            r_lat2 <= {{1{i_second_latitude[29]}}, i_second_latitude, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_f1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_p1_vld  <= i_valid;
            r_f1_vld  <= at_vld;
            r_out_vld <= r_f1_vld;
        end
    end

    hav_angle u_ang_dlat (.i_clk, .i_rst_n, .i_en(en), .i_vld(r_p1_vld), .i_deg(r_dlat),
        .o_vld(ang_vld[0]), .o_rad(ang_rad[0]), .o_flip(ang_flip[0]));
    hav_angle u_ang_dlon (.i_clk, .i_rst_n, .i_en(en), .i_vld(r_p1_vld), .i_deg(r_dlon),
        .o_vld(ang_vld[1]), .o_rad(ang_rad[1]), .o_flip(ang_flip[1]));
    hav_angle u_ang_lat1 (.i_clk, .i_rst_n, .i_en(en), .i_vld(r_p1_vld), .i_deg(r_lat1),
        .o_vld(ang_vld[2]), .o_rad(ang_rad[2]), .o_flip(ang_flip[2]));
    hav_angle u_ang_lat2 (.i_clk, .i_rst_n, .i_en(en), .i_vld(r_p1_vld), .i_deg(r_lat2),
        .o_vld(ang_vld[3]), .o_rad(ang_rad[3]), .o_flip(ang_flip[3]));

    for (genvar l = 0; l < 4; l++) begin : g_trig
        hav_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_cs (
            .i_clk, .i_rst_n, .i_en(en), .i_vld(ang_vld[l]),
            .i_x(INV_GAIN_Q30), .i_y('0), .i_z(ang_rad[l]), .i_flip(ang_flip[l]),
            .o_vld(cs_vld[l]), .o_x(cs_x[l]), .o_y(cs_y[l]), .o_z(cs_z[l])
        );
    end

    hav_mix u_mix (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(cs_vld[0]),
        .i_s_lat(cs_y[0]), .i_s_lon(cs_y[1]), .i_c1(cs_x[2]), .i_c2(cs_x[3]),
        .o_vld(mix_vld), .o_a(mix_a), .o_b(mix_b)
    );

    hav_isqrt u_sqrt_a (.i_clk, .i_rst_n, .i_en(en), .i_vld(mix_vld),
        .i_n(64'(mix_a) << 30), .o_vld(sq_vld_a), .o_root(root_a));
    hav_isqrt u_sqrt_b (.i_clk, .i_rst_n, .i_en(en), .i_vld(mix_vld),
        .i_n(64'(mix_b) << 30), .o_vld(sq_vld_b), .o_root(root_b));

    hav_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1)) u_atan (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(sq_vld_a),
        .i_x(t_q30'(root_b)), .i_y(t_q30'(root_a)), .i_z('0), .i_flip(1'b0),
        .o_vld(at_vld), .o_x(at_x), .o_y(at_y), .o_z(at_z)
    );

    // A slightly negative angle counts as zero; the distance uses twice it.
    assign w_ang2 = at_z[33] ? '0 : {at_z[30:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= 56'(r_radius) * 56'(w_ang2);
            r_dist <= r_prod[55:14];
        end
    end

    assign o_valid        = r_out_vld;
    assign o_arc_distance = r_dist;

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cs_vld[0] == cs_vld[3]) && (sq_vld_a == sq_vld_b))
        else $error("pipeline lanes out of step");

    a_a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mix_vld |-> (({1'b0, mix_a} + {1'b0, mix_b}) == 32'(ONE_Q30)))
        else $error("haversine term outside 0..1");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_vld_a |-> (root_a <= 32'(ONE_Q30) && root_b <= 32'(ONE_Q30)))
        else $error("square root above one");

    a_final_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f1_vld && en) |=> r_out_vld)
        else $error("word lost before output register");

endmodule
`default_nettype wire

@@ test/haversine_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_checker
// Watches the input and output channels of the great-circle distance block,
// predicts each distance from the accepted coordinates and the current radius,
// and compares every output word with the oldest prediction in order.
// ----------------------------------------------------------------------------
module haversine_checker #(
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [23:0]        i_cfg_wdata,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic signed [29:0] i_first_latitude,
    input  wire logic signed [30:0] i_first_longitude,
    input  wire logic signed [29:0] i_second_latitude,
    input  wire logic signed [30:0] i_second_longitude,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [41:0]        i_arc_distance,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_seen
);

    localparam longint DEG360 = 64'sd3019898880;
    localparam longint DEG180 = 64'sd1509949440;
    localparam longint DEG90  = 64'sd754974720;
    localparam longint RAD_PER_DEG = 64'sd18740330;
    localparam longint GAIN_INV = 64'sd652032874;
    localparam longint UNIT = 64'sd1073741824;
    localparam longint DIST_MAX = 64'sd4398046511103;

    logic [23:0] radius;
    logic [41:0] distance_queue[$];

    function automatic longint arctan_step(input int i);
        longint t[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
            255, 127, 63, 31, 15, 7, 3, 1};
        return (i < 30) ? t[i] : 0;
    endfunction

    // The >>> operator on a signed longint floors, as the hardware does.
    function automatic void rotate(input longint deg, output longint s,
                                   output longint c);
        longint r, x, y, z, dx, dy;
        bit flip;
        r = deg % DEG360;
        flip = 0;
        if (r < 0) r += DEG360;
        if (r >= DEG180) r -= DEG360;
        if (r > DEG90) begin
            r = DEG180 - r;
            flip = 1;
        end else if (r < -DEG90) begin
            r = -DEG180 - r;
            flip = 1;
        end
        z = (r * RAD_PER_DEG) >>> 23;
        x = GAIN_INV;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_step(i);
            end else begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    function automatic longint root_floor(input longint unsigned n);
        longint unsigned res, b;
        res = 0;
        for (int k = 0; k < 32; k++) begin
            b = 64'd1 << (62 - 2 * k);
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(input longint y, input longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += arctan_step(i);
            end else begin
                x -= dx; y += dy; z -= arctan_step(i);
            end
        end
        return z;
    endfunction

    function automatic logic [41:0] great_circle(input longint lat1, input longint lon1,
            input longint lat2, input longint lon2, input logic [23:0] r);
        longint s_lat, s_lon, c1, c2, unused, a, ra, rb, ang;
        longint unsigned d;
        rotate(lat2 - lat1, s_lat, unused);
        rotate(lon2 - lon1, s_lon, unused);
        rotate(lat1 * 2, unused, c1);
        rotate(lat2 * 2, unused, c2);
        a = ((s_lat * s_lat) >>> 30)
            + (((((c1 * c2) >>> 30)) * ((s_lon * s_lon) >>> 30)) >>> 30);
        if (a < 0) a = 0;
        if (a > UNIT) a = UNIT;
        ra = root_floor(longint'(a) << 30);
        rb = root_floor(longint'(UNIT - a) << 30);
        ang = vector_angle(ra, rb);
        if (ang < 0) ang = 0;
        d = (longint'(r) * (ang * 2)) >> 14;
        if (d > DIST_MAX) d = DIST_MAX;
        return d[41:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radius <= 24'd6371000;
        end else begin
            if (i_cfg_we) radius <= i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                distance_queue.push_back(great_circle(i_first_latitude,
                    i_first_longitude, i_second_latitude, i_second_longitude,
                    radius));
            if (i_out_valid && i_out_ready) begin
                o_seen <= o_seen + 1;
                if (distance_queue.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %0d",
                             $time, i_arc_distance);
                    o_fail_count <= o_fail_count + 1;
                end else if (distance_queue[0] !== i_arc_distance) begin
                    $display("%0t: arc_distance mismatch, expected %0d, actual %0d",
                             $time, distance_queue[0], i_arc_distance);
                    o_fail_count <= o_fail_count + 1;
                    void'(distance_queue.pop_front());
                end else begin
                    void'(distance_queue.pop_front());
                end
            end
            o_pending <= distance_queue.size();
        end
    end

    initial begin
        o_fail_count = 0;
        o_seen = 0;
        o_pending = 0;
    end

endmodule

@@ test/tb_haversine_distance.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_haversine_distance
// Drives coordinate pairs into the great-circle distance pipeline under
// several idling patterns and radius settings; the checker predicts and
// compares every distance word.
// ----------------------------------------------------------------------------
module tb_haversine_distance;

    import hav_pkg::*;

    localparam int LATENCY = 40 + 2 * 24;
    localparam longint LAT_MAX = 377487360;
    localparam longint LON_MAX = 754974720;
    localparam longint CYCLE_LIMIT = 400000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [23:0]        cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [29:0] lat1 = '0;
    logic signed [30:0] lon1 = '0;
    logic signed [29:0] lat2 = '0;
    logic signed [30:0] lon2 = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [41:0]        arc_distance;
    int                 fail_count, pending, seen;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    bit                 hold_off = 0;
    longint             cycles = 0;
    int                 sent = 0;

    always #1 clk = ~clk;

    haversine_distance i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_first_latitude(lat1), .i_first_longitude(lon1),
        .i_second_latitude(lat2), .i_second_longitude(lon2),
        .o_valid(out_valid), .i_ready(out_ready), .o_arc_distance(arc_distance)
    );

    haversine_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_first_latitude(lat1), .i_first_longitude(lon1),
        .i_second_latitude(lat2), .i_second_longitude(lon2),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_arc_distance(arc_distance),
        .o_fail_count(fail_count), .o_pending(pending), .o_seen(seen)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (hold_off) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic longint pick(input longint span);
        case ($urandom_range(9))
            0: return span;
            1: return -span;
            2: return 0;
            3: return longint'($urandom_range(2000)) - 1000;
            default: return longint'($urandom_range(32'(2 * span))) - span;
        endcase
    endfunction

    // Offers one word and holds it until the block takes it. Valid stays
    // high after acceptance so that words can follow back to back; it drops
    // when the sender idles or drains.
    task automatic offer(input longint a, input longint b, input longint c,
                         input longint d);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        lat1 <= a[29:0]; lon1 <= b[30:0]; lat2 <= c[29:0]; lon2 <= d[30:0];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic set_radius(input logic [23:0] r);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_pairs(input int n);
        for (int k = 0; k < n; k++) begin
            // A few words carry raw bit patterns beyond the nominal ranges.
            if ($urandom_range(19) == 0)
                offer(longint'($urandom) - 64'sd2147483648,
                      longint'($urandom) - 64'sd2147483648,
                      longint'($urandom) - 64'sd2147483648,
                      longint'($urandom) - 64'sd2147483648);
            else
                offer(pick(LAT_MAX), pick(LON_MAX), pick(LAT_MAX), pick(LON_MAX));
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identical points, poles, antipodes, field extremes, wrap.
        offer(0, 0, 0, 0);
        offer(LAT_MAX, 0, -LAT_MAX, 0);
        offer(0, 0, 0, LON_MAX);
        offer(0, -LON_MAX, 0, LON_MAX);
        offer(0, 0, 0, LON_MAX - 1);
        offer(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        offer(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        offer(-536870912, -1073741824, 536870911, 1073741823);
        offer(536870911, 1073741823, -536870912, -1073741824);
        offer(LAT_MAX + 4194304, 0, LAT_MAX + 4194304, 4194304);
        offer(500000000, 100, -500000000, 99999999);
        offer(1, 1, 2, 2);
        offer(-1, -1, -1, -1);
        offer(212000000, 30000000, 213000000, 31000000);
        set_radius(24'd1);
        offer(0, 0, 0, LON_MAX);
        set_radius(24'hFFFFFF);
        offer(0, 0, 0, LON_MAX);
        offer(LAT_MAX, 0, -LAT_MAX, 0);
        set_radius(24'd0);
        offer(0, 0, 0, LON_MAX);

        set_radius(24'd6371000);
        send_idle_pct = 0; recv_stall_pct = 0;
        random_pairs(400);
        set_radius(24'hFFFFFF);
        send_idle_pct = 50; recv_stall_pct = 0;
        random_pairs(300);
        set_radius(24'd1);
        send_idle_pct = 0; recv_stall_pct = 50;
        random_pairs(300);
        set_radius(24'($urandom_range(16777215, 1)));
        send_idle_pct = 17; recv_stall_pct = 17;
        random_pairs(300);

        // Long receiver hold-off so the pipeline fills and stalls its input.
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            random_pairs(200);
        join
        drain();
        send_idle_pct = 0; recv_stall_pct = 0;
        random_pairs(100);

        drain();
        $display("Sent %0d coordinate pairs, checked %0d distances over five radius",
                 sent, seen);
        $display("settings, with idling, stalling and a full-pipeline hold-off.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/hav_pkg.sv
rtl/core/hav_angle.sv
rtl/core/hav_cordic.sv
rtl/core/hav_mix.sv
rtl/core/hav_isqrt.sv
rtl/core/haversine_distance.sv
test/haversine_checker.sv
test/tb_haversine_distance.sv
